// File: rtl/core/ncc_pkg.sv
package ncc_pkg;

    localparam int MAX_CLUSTERS_DEF = 16;
    localparam int DIMS_DEF         = 4;

    localparam int COORD_W          = 16;
    localparam int CIDX_W           = 4;
    localparam int NUM_CLUSTERS_W   = 5;
    localparam int NUM_COORDS_W     = 3;
    localparam int CFG_INDEX_W      = 1;
    localparam int CFG_DATA_W       = 5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CLUSTERS = 1'b0,
        REG_COORDS   = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        OP_LOAD     = 1'b0,
        OP_CLASSIFY = 1'b1
    } op_t;

endpackage

// File: rtl/core/ncc_dist.sv
module ncc_dist
    import ncc_pkg::*;
#(
    parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
    parameter int DIMS         = DIMS_DEF,
    parameter int SUM_W        = 2*COORD_W + $clog2(DIMS)
)
(
    input  logic                                          clk,
    input  logic [2:0]                                    stage_en,
    input  logic [DIMS-1:0][COORD_W-1:0]                  sample,
    input  logic [MAX_CLUSTERS-1:0][DIMS-1:0][COORD_W-1:0] centroid,
    input  logic [DIMS-1:0]                               dim_on,
    output logic [MAX_CLUSTERS-1:0][SUM_W-1:0]            sq_dist
);

    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W   = 2*COORD_W;
    localparam int PROD_W = 2*DIFF_W;

    logic [MAX_CLUSTERS-1:0][DIMS-1:0][DIFF_W-1:0] diff_reg, diff_next;
    logic [MAX_CLUSTERS-1:0][DIMS-1:0][SQ_W-1:0]   sq_reg, sq_next;
    logic [MAX_CLUSTERS-1:0][SUM_W-1:0]            sum_reg, sum_next;

    // coordinate differences, unused dimensions forced to zero
    always_comb
    begin
        for (int k = 0; k < MAX_CLUSTERS; k++)
        begin
            for (int c = 0; c < DIMS; c++)
            begin
                if (dim_on[c])
                begin
                    diff_next[k][c] = {centroid[k][c][COORD_W-1], centroid[k][c]}
                                    - {sample[c][COORD_W-1], sample[c]};
                end
                else
                begin
                    diff_next[k][c] = '0;
                end
            end
        end
    end

    // |d| <= 65535, so the square fits the low 32 bits of the product
    always_comb
    begin
        logic signed [PROD_W-1:0] prod;
        prod = '0;
        for (int k = 0; k < MAX_CLUSTERS; k++)
        begin
            for (int c = 0; c < DIMS; c++)
            begin
                prod = $signed(diff_reg[k][c]) * $signed(diff_reg[k][c]);
                sq_next[k][c] = prod[SQ_W-1:0];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAX_CLUSTERS; k++)
        begin
            sum_next[k] = '0;
            for (int c = 0; c < DIMS; c++)
            begin
                sum_next[k] = sum_next[k] + SUM_W'(sq_reg[k][c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            diff_reg <= diff_next;
        end
        if (stage_en[1])
        begin
            sq_reg <= sq_next;
        end
        if (stage_en[2])
        begin
            sum_reg <= sum_next;
        end
    end

    assign sq_dist = sum_reg;

endmodule

// File: rtl/core/ncc_min_tree.sv
module ncc_min_tree
    import ncc_pkg::*;
#(
    parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
    parameter int SUM_W        = 2*COORD_W + $clog2(DIMS_DEF),
    parameter int LEVELS       = $clog2(MAX_CLUSTERS)
)
(
    input  logic                               clk,
    input  logic [LEVELS-1:0]                  stage_en,
    input  logic [MAX_CLUSTERS-1:0][SUM_W-1:0] sq_dist,
    input  logic [MAX_CLUSTERS-1:0]            lane_on,
    output logic [LEVELS-1:0]                  best_idx
);

    localparam int LEAVES = 1 << LEVELS;

    logic [SUM_W-1:0]  leaf_d [LEAVES];
    logic [LEVELS-1:0] leaf_i [LEAVES];
    logic              leaf_v [LEAVES];

    // heap order: node j has children 2j and 2j+1, node 1 is the root
    logic [SUM_W-1:0]  node_d_reg [1:LEAVES-1];
    logic [LEVELS-1:0] node_i_reg [1:LEAVES-1];
    logic              node_v_reg [1:LEAVES-1];

    for (genvar j = 0; j < LEAVES; j++)
    begin : g_leaf
        assign leaf_i[j] = LEVELS'(j);
        if (j < MAX_CLUSTERS)
        begin : g_lane
            assign leaf_d[j] = sq_dist[j];
            assign leaf_v[j] = lane_on[j];
        end
        else
        begin : g_pad
            assign leaf_d[j] = '0;
            assign leaf_v[j] = 1'b0;
        end
    end

    for (genvar j = 1; j < LEAVES; j++)
    begin : g_node
        localparam int LVL = LEVELS - ($clog2(j + 1) - 1);

        logic [SUM_W-1:0]  l_d, r_d, node_d_next;
        logic [LEVELS-1:0] l_i, r_i, node_i_next;
        logic              l_v, r_v, node_v_next;
        logic              pick_r;

        if (2*j >= LEAVES)
        begin : g_from_leaf
            assign l_d = leaf_d[2*j - LEAVES];
            assign l_i = leaf_i[2*j - LEAVES];
            assign l_v = leaf_v[2*j - LEAVES];
            assign r_d = leaf_d[2*j + 1 - LEAVES];
            assign r_i = leaf_i[2*j + 1 - LEAVES];
            assign r_v = leaf_v[2*j + 1 - LEAVES];
        end
        else
        begin : g_from_node
            assign l_d = node_d_reg[2*j];
            assign l_i = node_i_reg[2*j];
            assign l_v = node_v_reg[2*j];
            assign r_d = node_d_reg[2*j + 1];
            assign r_i = node_i_reg[2*j + 1];
            assign r_v = node_v_reg[2*j + 1];
        end

        // left holds the lower indices, so it wins a tie
        assign pick_r      = r_v && (!l_v || (r_d < l_d));
        assign node_d_next = pick_r ? r_d : l_d;
        assign node_i_next = pick_r ? r_i : l_i;
        assign node_v_next = l_v || r_v;

        always_ff @(posedge clk)
        begin
            if (stage_en[LVL-1])
            begin
                node_d_reg[j] <= node_d_next;
                node_i_reg[j] <= node_i_next;
                node_v_reg[j] <= node_v_next;
            end
        end
    end

    assign best_idx = node_i_reg[1];

endmodule

// File: rtl/core/nearest_centroid_classifier_core.sv
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tuser: operation; tdata: cluster_index, coord0..3
// m_*       out  m_tvalid/m_tready    tdata: nearest_cluster
// cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle unless the output stalls. A classify item passes the
// difference, square and sum stages, then one registered level of the compare
// tree per halving of the centroid lanes. A load writes its centroid at the edge
// it is taken and gives no result. Reset clears the stage valids and sets the
// config registers to one cluster and four coordinates; the centroid table holds
// garbage until loaded. Every stage has its own ready, so bubbles close up behind
// a stalled output and nothing is dropped or repeated.
module nearest_centroid_classifier_core
    import ncc_pkg::*;
#(
    parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
    parameter int DIMS         = DIMS_DEF,
    localparam int S_TDATA_W   = ((CIDX_W + DIMS*COORD_W + 7) / 8) * 8,
    localparam int M_TDATA_W   = ((CIDX_W + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // cluster_index, coord0 .. coord(DIMS-1)
    input  logic                   s_tuser,   // operation

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // nearest_cluster

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int LEVELS = $clog2(MAX_CLUSTERS);
    localparam int NSTAGE = 3 + LEVELS;
    localparam int SUM_W  = 2*COORD_W + $clog2(DIMS);

    logic [NUM_CLUSTERS_W-1:0] clusters_reg;
    logic [NUM_COORDS_W-1:0]   coords_reg;

    logic [MAX_CLUSTERS-1:0][DIMS-1:0][COORD_W-1:0] centroid_reg;

    logic [NSTAGE-1:0] vld_reg, vld_next;
    logic [NSTAGE:0]   stage_rdy;

    logic [DIMS-1:0][COORD_W-1:0]       sample;
    logic [CIDX_W-1:0]                  slot;
    logic                               s_accept;
    logic [DIMS-1:0]                    dim_on;
    logic [MAX_CLUSTERS-1:0]            lane_on;
    logic [MAX_CLUSTERS-1:0][SUM_W-1:0] sq_dist;
    logic [LEVELS-1:0]                  best_idx;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clusters_reg <= NUM_CLUSTERS_W'(1);
            coords_reg   <= NUM_COORDS_W'(4);
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CLUSTERS: clusters_reg <= cfg_data;
                REG_COORDS:   coords_reg   <= cfg_data[NUM_COORDS_W-1:0];
                default:      ;
            endcase
        end
    end

    // lane 0 always competes; counts above the hardware size saturate naturally
    always_comb
    begin
        for (int k = 0; k < MAX_CLUSTERS; k++)
        begin
            lane_on[k] = (k == 0) || (k < int'(clusters_reg));
        end
        for (int c = 0; c < DIMS; c++)
        begin
            dim_on[c] = c < int'(coords_reg);
        end
    end

    always_comb
    begin
        slot = s_tdata[CIDX_W-1:0];
        for (int c = 0; c < DIMS; c++)
        begin
            sample[c] = s_tdata[CIDX_W + c*COORD_W +: COORD_W];
        end
    end

    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_CLUSTERS; k++)
        begin
            if (s_accept && (op_t'(s_tuser) == OP_LOAD) && (int'(slot) == k))
            begin
                centroid_reg[k] <= sample;
            end
        end
    end

    // per-stage ready: a stage may load when empty or when the next one moves
    always_comb
    begin
        stage_rdy[NSTAGE] = m_tready;
        for (int i = NSTAGE - 1; i >= 0; i--)
        begin
            stage_rdy[i] = !vld_reg[i] || stage_rdy[i+1];
        end
    end

    assign s_tready = stage_rdy[0];

    always_comb
    begin
        vld_next = vld_reg;
        if (stage_rdy[0])
        begin
            vld_next[0] = s_tvalid && (op_t'(s_tuser) == OP_CLASSIFY);
        end
        for (int i = 1; i < NSTAGE; i++)
        begin
            if (stage_rdy[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    ncc_dist #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .DIMS         (DIMS),
        .SUM_W        (SUM_W)
    ) u_dist (
        .clk      (clk),
        .stage_en (stage_rdy[2:0]),
        .sample   (sample),
        .centroid (centroid_reg),
        .dim_on   (dim_on),
        .sq_dist  (sq_dist)
    );

    ncc_min_tree #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .SUM_W        (SUM_W),
        .LEVELS       (LEVELS)
    ) u_min_tree (
        .clk      (clk),
        .stage_en (stage_rdy[NSTAGE-1:3]),
        .sq_dist  (sq_dist),
        .lane_on  (lane_on),
        .best_idx (best_idx)
    );

    assign m_tvalid = vld_reg[NSTAGE-1];
    assign m_tdata  = M_TDATA_W'(CIDX_W'(best_idx));

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&vld_reg))
        else $error("input blocked while a pipeline stage is empty");

    a_one_item_per_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(vld_reg) <= $countones($past(vld_reg)) + 1)
        else $error("pipeline gained more than one item in a cycle");

    a_no_lost_item: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[0] && !stage_rdy[1]) |=> vld_reg[0])
        else $error("stalled first stage lost its item");

endmodule

// File: tb/tb_nearest_centroid_classifier_core.sv
module tb_nearest_centroid_classifier_core;
    import ncc_pkg::*;

    localparam int IN_W        = ((CIDX_W + DIMS_DEF*COORD_W + 7) / 8) * 8;
    localparam int OUT_W       = ((CIDX_W + 7) / 8) * 8;
    localparam int PIPE_LAT    = 3 + $clog2(MAX_CLUSTERS_DEF);
    localparam int MAX_REPORTS = 10;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 56;

    typedef logic [DIMS_DEF-1:0][COORD_W-1:0] coord_vec_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata;    // cluster_index, coord0, coord1, coord2, coord3
    logic                   s_tuser;    // operation
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_W-1:0]       m_tdata;    // nearest_cluster
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // shadow of the block's state
    coord_vec_t                cent_tbl [MAX_CLUSTERS_DEF];
    logic [NUM_CLUSTERS_W-1:0] clusters_reg;
    logic [NUM_COORDS_W-1:0]   coords_reg;

    logic [CIDX_W-1:0] pending_nearest [$];
    logic [CIDX_W-1:0] want_nearest;
    int                mismatches = 0;
    bit                gaps_on;
    bit                stalls_on;

    nearest_centroid_classifier_core #(
        .MAX_CLUSTERS(MAX_CLUSTERS_DEF),
        .DIMS(DIMS_DEF)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [CIDX_W-1:0] nearest_centroid(coord_vec_t pt);
        int unsigned       nk;
        int unsigned       nc;
        int unsigned       k;
        int unsigned       c;
        longint            d;
        longint unsigned   sq_dist;
        longint unsigned   best_dist;
        logic [CIDX_W-1:0] best;
        nk = clusters_reg;
        if (nk == 0)
            nk = 1;
        if (nk > MAX_CLUSTERS_DEF)
            nk = MAX_CLUSTERS_DEF;
        nc = coords_reg;
        if (nc > DIMS_DEF)
            nc = DIMS_DEF;
        best = '0;
        best_dist = 0;
        for (k = 0; k < nk; k++)
        begin
            sq_dist = 0;
            for (c = 0; c < nc; c++)
            begin
                d = longint'($signed(cent_tbl[k][c])) - longint'($signed(pt[c]));
                sq_dist = sq_dist + d * d;
            end
            // strict compare: lowest index wins a tie
            if (k == 0 || sq_dist < best_dist)
            begin
                best_dist = sq_dist;
                best = CIDX_W'(k);
            end
        end
        return best;
    endfunction

    // mix of exact centroid copies (ties), near misses, rails and full-range noise
    function automatic coord_vec_t random_point();
        coord_vec_t pt;
        coord_vec_t anchor;
        int         c;
        int         mode;
        anchor = cent_tbl[$urandom_range(0, MAX_CLUSTERS_DEF-1)];
        mode = $urandom_range(0, 9);
        for (c = 0; c < DIMS_DEF; c++)
        begin
            case (mode)
                0:       pt[c] = anchor[c];
                1, 2, 3: pt[c] = anchor[c] + COORD_W'($urandom_range(0, 64)) - 16'd32;
                4:       pt[c] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                default: pt[c] = COORD_W'($urandom);
            endcase
        end
        return pt;
    endfunction

    task automatic send_item(op_t op, logic [CIDX_W-1:0] slot, coord_vec_t pt);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_W - CIDX_W - DIMS_DEF*COORD_W){1'b0}}, pt, slot};
        do @(posedge clk); while (!s_tready);
        if (op == OP_LOAD)
            cent_tbl[slot] = pt;
        else
            pending_nearest = {pending_nearest, nearest_centroid(pt)};
    endtask

    task automatic load(logic [CIDX_W-1:0] slot, coord_vec_t pt);
        send_item(OP_LOAD, slot, pt);
    endtask

    task automatic classify(coord_vec_t pt);
        send_item(OP_CLASSIFY, CIDX_W'($urandom_range(0, MAX_CLUSTERS_DEF-1)), pt);
    endtask

    // stop sending, wait out every pending result, then let a trailing load drain
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_nearest.size() != 0);
        repeat (PIPE_LAT + 2) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_CLUSTERS)
            clusters_reg = val[NUM_CLUSTERS_W-1:0];
        else
            coords_reg = val[NUM_COORDS_W-1:0];
        @(posedge clk);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] clusters, logic [CFG_DATA_W-1:0] coords);
        settle();
        write_reg(REG_CLUSTERS, clusters);
        write_reg(REG_COORDS, coords);
    endtask

    // fill every slot first so no classify ever reads an unloaded centroid
    task automatic test_reset_values();
        int i;
        load(0, {DIMS_DEF{16'h8000}});
        load(MAX_CLUSTERS_DEF-1, {DIMS_DEF{16'h7fff}});
        for (i = 1; i < MAX_CLUSTERS_DEF-1; i++)
            load(CIDX_W'(i), random_point());
        classify({DIMS_DEF{16'h7fff}});
        classify(random_point());
    endtask

    task automatic test_extremes();
        configure(MAX_CLUSTERS_DEF, DIMS_DEF);
        classify({DIMS_DEF{16'h7fff}});
        classify({DIMS_DEF{16'h8000}});
        classify('0);
    endtask

    task automatic test_ties();
        load(6, {DIMS_DEF{16'd1234}});
        load(11, {DIMS_DEF{16'd1234}});
        classify({DIMS_DEF{16'd1234}});
    endtask

    task automatic test_register_limits();
        configure(0, DIMS_DEF);
        classify(random_point());
        configure(31, DIMS_DEF);
        classify(random_point());
        configure(MAX_CLUSTERS_DEF, 0);
        classify(random_point());
        configure(MAX_CLUSTERS_DEF, 7);
        classify(random_point());
    endtask

    task automatic test_random_traffic();
        int unsigned k_set [PHASES] = '{16, 1, 17, 2, 8, 0, 31, 16};
        int unsigned n_set [PHASES] = '{4, 1, 7, 2, 0, 3, 5, 4};
        int          ph;
        int          i;
        for (ph = 0; ph < PHASES; ph++)
        begin
            gaps_on   = (ph != PHASES-1) && (ph % 3 != 2);
            stalls_on = (ph != PHASES-1) && (ph % 4 != 1);
            if (ph == 4)
                configure(CFG_DATA_W'($urandom_range(0, 31)),
                          CFG_DATA_W'($urandom_range(0, 7)));
            else
                configure(CFG_DATA_W'(k_set[ph]), CFG_DATA_W'(n_set[ph]));
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    load(CIDX_W'($urandom_range(0, MAX_CLUSTERS_DEF-1)), random_point());
                else
                    classify(random_point());
            end
        end
    endtask

    // output side: random backpressure bursts
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold == 0 && stalls_on && $urandom_range(0, 4) == 0)
                hold = $urandom_range(1, 5);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_nearest.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected item: nearest_cluster %0d at %0t",
                             m_tdata[CIDX_W-1:0], $time);
            end
            else
            begin
                want_nearest = pending_nearest.pop_front();
                if (m_tdata[CIDX_W-1:0] !== want_nearest)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("nearest_cluster mismatch: expected %0d, got %0d at %0t",
                                 want_nearest, m_tdata[CIDX_W-1:0], $time);
                end
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= OP_LOAD;
        s_tdata   <= '0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_CLUSTERS;
        cfg_data  <= '0;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        foreach (cent_tbl[i])
            cent_tbl[i] = '0;
        clusters_reg = 1;
        coords_reg   = 4;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_extremes();
        test_ties();
        test_register_limits();
        test_random_traffic();
        settle();

        if (mismatches == 0 && pending_nearest.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
